// ===== src/wtd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_pkg: shared types and constants for the waypoint turn-then-drive unit
// payload structs, register map, fixed-point constants and the atan table
// ----------------------------------------------------------------------------
package wtd_pkg;

  // route and cordic sizing
  localparam int NUM_POINTS  = 4;
  localparam int ANGLE_ITERS = 14;
  localparam int ITER_W      = 4;   // indexes the 16-entry atan table
  localparam int CORDIC_W    = 20;  // x and y working width
  localparam int ANG_W       = 21;  // angle accumulator width, 2^-16 rad

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ANGLE_ITERS - 1);

  // register map, word index
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W   = 5;
  localparam logic [REG_IDX_W-1:0] REG_WP0      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WP1      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WP2      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WP3      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEAD_TOL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_POS_TOL  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FWD      = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TURN     = 3'd7;

  // fixed-point angles
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [ANG_W-1:0] PI_Q16 = 21'sd205887;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] yaw;
  } wtd_in_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic               drive_mode;
    logic [2:0]         waypoint_index;
  } wtd_out_t;

  typedef struct packed {
    logic [3:0][31:0]   waypoint_xy;
    logic [14:0]        heading_tol;
    logic [14:0]        position_tol;
    logic signed [15:0] forward_speed;
    logic signed [15:0] turn_rate;
  } wtd_cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } wtd_cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] angle;
  } wtd_cordic_rsp_t;

  // atan(2^-i) in units of 2^-16 rad
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      4'd0:    v = 21'sd51472;
      4'd1:    v = 21'sd30386;
      4'd2:    v = 21'sd16055;
      4'd3:    v = 21'sd8150;
      4'd4:    v = 21'sd4091;
      4'd5:    v = 21'sd2047;
      4'd6:    v = 21'sd1024;
      4'd7:    v = 21'sd512;
      4'd8:    v = 21'sd256;
      4'd9:    v = 21'sd128;
      4'd10:   v = 21'sd64;
      4'd11:   v = 21'sd32;
      4'd12:   v = 21'sd16;
      4'd13:   v = 21'sd8;
      4'd14:   v = 21'sd4;
      default: v = 21'sd2;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/waypoint_turn_then_drive_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_turn_then_drive_unit: turn-then-drive waypoint follower
// pose in, velocity command out, bearing by an iterative cordic
// ----------------------------------------------------------------------------
// usage
//   in_*  : one pose (x, y, yaw, signed q3.12) per transfer
//   out_* : one command per pose while the route is active; once the last
//           waypoint is reached a pose is taken and gives no result
//   apb   : route and command registers, written while the block is idle
// timing
//   turning tick: the cordic loads at the accept edge, then runs ANGLE_ITERS
//   iterations, 14 by default (one micro-rotation each through the shared
//   add/sub and shifter); then the bearing is taken and the evaluation step
//   loads the result into the output register
//   zero offset to the waypoint: bearing 0 at once, with no micro-rotations
//   driving tick: stored bearing is reused, straight to the evaluation step
//   in_stall is high from accept until the result is loaded in the output
//   register; the next pose can be taken while that result still waits
// reset
//   synchronous, active low: turning mode, waypoint 0, bearing 0, default
//   registers, no result pending
// receiver stall
//   out_data holds while out_stall is high; a finished item waits in the
//   evaluation step until the output register frees, keeping in_stall high
// ----------------------------------------------------------------------------
module waypoint_turn_then_drive_unit import wtd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // pose channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire wtd_in_t            in_data,
  // command channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output wtd_out_t                out_data,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {S_IDLE, S_BEARING, S_EMIT} state_t;

  state_t              state_r;
  wtd_cfg_t            cfg;
  wtd_cordic_req_t     creq;
  wtd_cordic_rsp_t     crsp;

  // item and route state
  logic                mode_r;
  logic [2:0]          point_r;
  logic signed [15:0]  target_r;
  logic signed [16:0]  dx_r, dy_r, yaw_r;
  logic                out_valid_r;
  wtd_out_t            out_r;

  // accept-side logic
  logic                accept, route_live, out_free;
  logic [31:0]         wp;
  logic signed [15:0]  wx, wy;
  logic signed [16:0]  dx_in, dy_in, yaw_a, yaw_b;

  // evaluation logic
  logic signed [16:0]  err_diff;
  logic [16:0]         err_abs, dx_abs, dy_abs, htol, ptol;
  logic                arrive;
  wtd_out_t            res;
  logic                mode_nxt;
  logic [2:0]          point_nxt;

  wtd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign route_live = (point_r < 3'(NUM_POINTS));
  assign out_free   = !out_valid_r || !out_stall;

  // offset to the current waypoint at full 17-bit width
  always_comb begin
    wp    = cfg.waypoint_xy[point_r[1:0]];
    wx    = wp[15:0];
    wy    = wp[31:16];
    dx_in = {wx[15], wx} - {in_data.pos_x[15], in_data.pos_x};
    dy_in = {wy[15], wy} - {in_data.pos_y[15], in_data.pos_y};
  end

  // yaw fold into about minus pi to pi
  always_comb begin
    yaw_a = {in_data.yaw[15], in_data.yaw};
    if (yaw_a >= TWO_PI_Q12)       yaw_a = yaw_a - TWO_PI_Q12;
    else if (yaw_a <= -TWO_PI_Q12) yaw_a = yaw_a + TWO_PI_Q12;
    yaw_b = yaw_a;
    if (yaw_a > PI_Q12)            yaw_b = yaw_a - TWO_PI_Q12;
    else if (yaw_a < -PI_Q12)      yaw_b = yaw_a + TWO_PI_Q12;
  end

  // cordic only runs on turning ticks
  assign creq.start = accept && route_live && !mode_r;
  assign creq.dx    = dx_in;
  assign creq.dy    = dy_in;

  // heading error is not wrapped
  always_comb begin
    err_diff = yaw_r - {target_r[15], target_r};
    err_abs  = err_diff[16] ? 17'(-err_diff) : 17'(err_diff);
    dx_abs   = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
    dy_abs   = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
    htol     = {2'b00, cfg.heading_tol};
    ptol     = {2'b00, cfg.position_tol};
    arrive   = (dx_abs < ptol) && (dy_abs < ptol);

    res.linear_cmd  = '0;
    res.angular_cmd = '0;
    mode_nxt        = mode_r;
    point_nxt       = point_r;
    if (!mode_r) begin
      // turning: enter driving once aligned, with no turn on that tick
      if (err_abs < htol) begin
        mode_nxt = 1'b1;
      end else begin
        res.angular_cmd = cfg.turn_rate;
      end
    end else begin
      res.linear_cmd = cfg.forward_speed;
      if (err_abs > htol) begin
        mode_nxt       = 1'b0;
        res.linear_cmd = '0;
      end
      if (arrive) begin
        // stop and move on to the next waypoint
        mode_nxt       = 1'b0;
        res.linear_cmd = '0;
        point_nxt      = point_r + 3'd1;
      end
    end
    res.drive_mode     = mode_nxt;
    res.waypoint_index = point_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      point_r     <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the emit step below sets the flag itself
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          // a pose after the last waypoint is taken and dropped
          if (accept && route_live) begin
            dx_r    <= dx_in;
            dy_r    <= dy_in;
            yaw_r   <= yaw_b;
            state_r <= mode_r ? S_EMIT : S_BEARING;
          end
        end
        S_BEARING: begin
          if (crsp.done) begin
            target_r <= crsp.angle;
            state_r  <= S_EMIT;
          end
        end
        default: begin
          if (out_free) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            mode_r      <= mode_nxt;
            point_r     <= point_nxt;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== src/wtd_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_regs: configuration register file
// apb-style write and read of the route and command registers
// ----------------------------------------------------------------------------
module wtd_regs import wtd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output wtd_cfg_t                cfg
);

  wtd_cfg_t               cfg_r;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waypoint_xy[0] <= 32'd2048;
      cfg_r.waypoint_xy[1] <= 32'd134219776;
      cfg_r.waypoint_xy[2] <= 32'd134217728;
      cfg_r.waypoint_xy[3] <= 32'd0;
      cfg_r.heading_tol    <= 15'd1229;
      cfg_r.position_tol   <= 15'd410;
      cfg_r.forward_speed  <= 16'sd410;
      cfg_r.turn_rate      <= -16'sd4096;
    end else if (wr_en) begin
      unique case (idx)
        REG_WP0:      cfg_r.waypoint_xy[0] <= pwdata;
        REG_WP1:      cfg_r.waypoint_xy[1] <= pwdata;
        REG_WP2:      cfg_r.waypoint_xy[2] <= pwdata;
        REG_WP3:      cfg_r.waypoint_xy[3] <= pwdata;
        REG_HEAD_TOL: cfg_r.heading_tol    <= pwdata[14:0];
        REG_POS_TOL:  cfg_r.position_tol   <= pwdata[14:0];
        REG_FWD:      cfg_r.forward_speed  <= pwdata[15:0];
        default:      cfg_r.turn_rate      <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WP0:      prdata = cfg_r.waypoint_xy[0];
      REG_WP1:      prdata = cfg_r.waypoint_xy[1];
      REG_WP2:      prdata = cfg_r.waypoint_xy[2];
      REG_WP3:      prdata = cfg_r.waypoint_xy[3];
      REG_HEAD_TOL: prdata = {17'd0, cfg_r.heading_tol};
      REG_POS_TOL:  prdata = {17'd0, cfg_r.position_tol};
      REG_FWD:      prdata = {16'd0, cfg_r.forward_speed};
      default:      prdata = {16'd0, cfg_r.turn_rate};
    endcase
  end

endmodule
`default_nettype wire

// ===== src/wtd_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtd_cordic: iterative cordic vectoring unit
// one micro-rotation per cycle through a shared add/sub and shifter
// ----------------------------------------------------------------------------
module wtd_cordic import wtd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire wtd_cordic_req_t req,
  output wtd_cordic_rsp_t      rsp
);

  typedef enum logic {C_IDLE, C_RUN} cstate_t;

  cstate_t                     state_r;
  logic [ITER_W-1:0]           iter_r;
  logic signed [CORDIC_W-1:0]  x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [CORDIC_W-1:0]  x_ext, y_ext;
  logic signed [ANG_W-1:0]     z_r, z_nxt, z_round;
  logic                        done_r;
  logic signed [15:0]          angle_r;

  assign x_ext = CORDIC_W'(req.dx);
  assign y_ext = CORDIC_W'(req.dy);

  // shared micro-rotation
  always_comb begin
    xs = x_r >>> iter_r;
    ys = y_r >>> iter_r;
    if (!y_r[CORDIC_W-1]) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + atan_q16(iter_r);
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - atan_q16(iter_r);
    end
    z_round = z_nxt + ANG_W'(8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      iter_r  <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          // zero vector gives bearing zero at once
          done_r <= req.start && (req.dx == '0) && (req.dy == '0);
          if (req.start) begin
            iter_r <= '0;
            if (req.dx == '0 && req.dy == '0) begin
              angle_r <= '0;
            end else begin
              state_r <= C_RUN;
              if (req.dx[16]) begin
                // pre-rotate left half plane by plus or minus pi
                x_r <= -x_ext;
                y_r <= -y_ext;
                z_r <= req.dy[16] ? -PI_Q16 : PI_Q16;
              end else begin
                x_r <= x_ext;
                y_r <= y_ext;
                z_r <= '0;
              end
            end
          end
        end
        default: begin
          x_r    <= x_nxt;
          y_r    <= y_nxt;
          z_r    <= z_nxt;
          iter_r <= iter_r + ITER_W'(1);
          done_r <= (iter_r == ITER_LAST);
          if (iter_r == ITER_LAST) begin
            state_r <= C_IDLE;
            angle_r <= z_round[19:4];
          end
        end
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.angle = angle_r;

endmodule
`default_nettype wire
